>>> rtl/assert_macros.svh
// assertion helpers used by the top-level rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal must never be high outside reset
`define ASSERT_NEVER(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

>>> rtl/eht_pkg.sv
package eht_pkg;

    localparam int TrigStagesDef  = 16;
    localparam int RotFracBitsDef = 14;
    localparam int AtanEntries    = 24;
    localparam int WorkFrac       = 30;
    localparam int CordW          = 44;   // q40 plus sign and headroom
    localparam int ZW             = 28;   // residual angle, 2^-20 degree
    localparam int AngW           = 17;
    localparam int TransW         = 24;
    localparam int FullTurn       = 46080;
    localparam int QuarterTurn    = 11520;
    localparam logic signed [CordW-1:0] GainQ40 = 44'sd667681663047;

    typedef logic [1:0] quad_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:    r = 28'sd47185920;
            5'd1:    r = 28'sd27855475;
            5'd2:    r = 28'sd14718068;
            5'd3:    r = 28'sd7471121;
            5'd4:    r = 28'sd3750058;
            5'd5:    r = 28'sd1876857;
            5'd6:    r = 28'sd938658;
            5'd7:    r = 28'sd469357;
            5'd8:    r = 28'sd234682;
            5'd9:    r = 28'sd117342;
            5'd10:   r = 28'sd58671;
            5'd11:   r = 28'sd29335;
            5'd12:   r = 28'sd14668;
            5'd13:   r = 28'sd7334;
            5'd14:   r = 28'sd3667;
            5'd15:   r = 28'sd1833;
            5'd16:   r = 28'sd917;
            5'd17:   r = 28'sd458;
            5'd18:   r = 28'sd229;
            5'd19:   r = 28'sd115;
            5'd20:   r = 28'sd57;
            5'd21:   r = 28'sd29;
            5'd22:   r = 28'sd14;
            5'd23:   r = 28'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

    // product of two q30 values rounded back to q30, half up
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

>>> rtl/eht_cordic_cell.sv
module eht_cordic_cell
    #(parameter int STAGE = 0)
    (
        input  logic                            clk,
        input  logic                            en,
        input  logic signed [eht_pkg::CordW-1:0] x_in,
        input  logic signed [eht_pkg::CordW-1:0] y_in,
        input  logic signed [eht_pkg::ZW-1:0]    z_in,
        output logic signed [eht_pkg::CordW-1:0] x_out,
        output logic signed [eht_pkg::CordW-1:0] y_out,
        output logic signed [eht_pkg::ZW-1:0]    z_out
    );
    import eht_pkg::*;

    logic signed [CordW-1:0] dx, dy;
    logic signed [ZW-1:0]    a;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;
    assign a  = atan_lut(5'(STAGE));

    // one micro-rotation toward zero residual
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[ZW-1])
            begin
                x_out <= x_in - dx;
                y_out <= y_in + dy;
                z_out <= z_in - a;
            end
            else
            begin
                x_out <= x_in + dx;
                y_out <= y_in - dy;
                z_out <= z_in + a;
            end
        end
    end
endmodule

>>> rtl/eht_trig.sv
module eht_trig
    #(parameter int TRIG_STAGES = eht_pkg::TrigStagesDef)
    (
        input  logic                          clk,
        input  logic                          en,
        input  logic signed [eht_pkg::AngW-1:0] angle,
        output logic signed [31:0]            cos_q30,
        output logic signed [31:0]            sin_q30
    );
    import eht_pkg::*;

    localparam int N = (TRIG_STAGES > AtanEntries) ? AtanEntries : TRIG_STAGES;

    logic signed [CordW-1:0] xs [0:N];
    logic signed [CordW-1:0] ys [0:N];
    logic signed [ZW-1:0]    zs [0:N];
    quad_t                   qs [0:N];
    logic signed [AngW+1:0]  r0, r1;
    logic [AngW-1:0]         rem;
    quad_t                   quad;
    logic signed [31:0]      cq, sq;
    logic signed [CordW-1:0] xr, yr;

    // wrap into [0, 360) with one correction, the 17 bit field stays within two turns of zero
    always_comb
    begin
        r0 = {{2{angle[AngW-1]}}, angle};
        if (r0 >= 19'sd46080)
            r1 = r0 - 19'sd46080;
        else if (r0 < -19'sd46080)
            r1 = r0 + 19'sd92160;
        else if (r0 < 0)
            r1 = r0 + 19'sd46080;
        else
            r1 = r0;
        if (r1 >= 19'sd34560)
        begin
            quad = 2'd3;
            rem  = 17'(r1 - 19'sd34560);
        end
        else if (r1 >= 19'sd23040)
        begin
            quad = 2'd2;
            rem  = 17'(r1 - 19'sd23040);
        end
        else if (r1 >= 19'sd11520)
        begin
            quad = 2'd1;
            rem  = 17'(r1 - 19'sd11520);
        end
        else
        begin
            quad = 2'd0;
            rem  = r1[AngW-1:0];
        end
    end

    assign xs[0] = GainQ40;
    assign ys[0] = '0;
    assign zs[0] = ZW'({rem, 13'd0});
    assign qs[0] = quad;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        eht_cordic_cell #(.STAGE(i)) u_cell (
            .clk(clk), .en(en),
            .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
            .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                qs[i+1] <= qs[i];
        end
    end

    assign xr = xs[N] + 44'sd512;
    assign yr = ys[N] + 44'sd512;
    assign cq = xr[41:10];
    assign sq = yr[41:10];

    always_comb
    begin
        unique case (qs[N])
            2'd0:    begin cos_q30 = cq;  sin_q30 = sq;  end
            2'd1:    begin cos_q30 = -sq; sin_q30 = cq;  end
            2'd2:    begin cos_q30 = -cq; sin_q30 = -sq; end
            default: begin cos_q30 = sq;  sin_q30 = -cq; end
        endcase
    end
endmodule

>>> rtl/euler_to_homogeneous_transform_unit.sv
// euler pose (z-y-x order) to the top three rows of a homogeneous transform
// input channel s_axis: one request per pose, tdata packs translation and
// three q9.7 degree angles; output channel m_axis: three requests per pose,
// rows 0, 1, 2 in order, tuser holds the row index, tlast marks row 2
// each angle runs through a chain of min(TRIG_STAGES, 24) cordic cells,
// then two product stages form the matrix and a rounding stage fills the buffer
// poses leave at the pace of the single output channel, three rows each;
// the pipeline advances only when its last stage is free
// a row buffer of three rows parts the pipeline from the output, so a new
// pose is taken while the previous rows are still being sent
// when the receiver stalls, the pipeline freezes once the buffer is held
// reset clears all valid flags; payload registers are not reset
module euler_to_homogeneous_transform_unit
    #(
        parameter int TRIG_STAGES   = eht_pkg::TrigStagesDef,
        parameter int ROT_FRAC_BITS = eht_pkg::RotFracBitsDef
    )
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         s_axis_tvalid,
        output logic         s_axis_tready,
        // trans_x, trans_y, trans_z, angle_about_y, angle_about_x,
        // angle_about_z, zero pad to 128
        input  logic [127:0] s_axis_tdata,
        output logic         m_axis_tvalid,
        input  logic         m_axis_tready,
        // col0, col1, col2, offset, zero pad
        output logic [3*(ROT_FRAC_BITS+2)+23+((8-((3*(ROT_FRAC_BITS+2)+24)%8))%8):0]
                             m_axis_tdata,
        // row_index
        output logic [1:0]   m_axis_tuser,
        output logic         m_axis_tlast
    );
    import eht_pkg::*;
    `include "assert_macros.svh"

    localparam int FB   = (ROT_FRAC_BITS > WorkFrac) ? WorkFrac : ROT_FRAC_BITS;
    localparam int CW   = ROT_FRAC_BITS + 2;
    localparam int DW   = 3*CW + TransW;
    localparam int NS   = (TRIG_STAGES > AtanEntries) ? AtanEntries : TRIG_STAGES;
    localparam int LAT  = NS + 2;   // cordic cells plus two product stages

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [TransW-1:0] tr_pipe_reg [0:LAT-1][0:2];

    logic signed [31:0] cy, sy, cx, sx, cz, sz;

    eht_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_y (
        .clk(clk), .en(en), .angle(s_axis_tdata[88:72]), .cos_q30(cy), .sin_q30(sy));
    eht_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_x (
        .clk(clk), .en(en), .angle(s_axis_tdata[105:89]), .cos_q30(cx), .sin_q30(sx));
    eht_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_z (
        .clk(clk), .en(en), .angle(s_axis_tdata[122:106]), .cos_q30(cz), .sin_q30(sz));

    // row buffer: three rows of one pose
    logic        buf_full_reg;
    logic [1:0]  row_reg;
    logic [CW-1:0] out_col_reg [0:2][0:2];
    logic [TransW-1:0] out_off_reg [0:2];
    logic        load;

    assign load = vld_reg[LAT-1] && (!buf_full_reg ||
                  (m_axis_tready && row_reg == 2'd2));
    assign en = !vld_reg[LAT-1] || load;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_pipe_reg[0][0] <= s_axis_tdata[23:0];
            tr_pipe_reg[0][1] <= s_axis_tdata[47:24];
            tr_pipe_reg[0][2] <= s_axis_tdata[71:48];
            for (int k = 1; k < LAT; k++)
                tr_pipe_reg[k] <= tr_pipe_reg[k-1];
        end
    end

    // stage a: first products
    logic signed [31:0] czsy_reg, szsy_reg, czcy_reg, szcy_reg, szcx_reg, szsx_reg;
    logic signed [31:0] czcx_reg, czsx_reg, cysx_reg, cycx_reg, nsy_reg, sx_reg, cx_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czsy_reg <= mulq(cz, sy);
            szsy_reg <= mulq(sz, sy);
            czcy_reg <= mulq(cz, cy);
            szcy_reg <= mulq(sz, cy);
            szcx_reg <= mulq(sz, cx);
            szsx_reg <= mulq(sz, sx);
            czcx_reg <= mulq(cz, cx);
            czsx_reg <= mulq(cz, sx);
            cysx_reg <= mulq(cy, sx);
            cycx_reg <= mulq(cy, cx);
            nsy_reg  <= -sy;
            sx_reg   <= sx;
            cx_reg   <= cx;
        end
    end

    // stage b: second products and sums
    logic signed [32:0] m_reg [0:2][0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0][0] <= 33'(czcy_reg);
            m_reg[0][1] <= 33'(mulq(czsy_reg, sx_reg)) - 33'(szcx_reg);
            m_reg[0][2] <= 33'(mulq(czsy_reg, cx_reg)) + 33'(szsx_reg);
            m_reg[1][0] <= 33'(szcy_reg);
            m_reg[1][1] <= 33'(mulq(szsy_reg, sx_reg)) + 33'(czcx_reg);
            m_reg[1][2] <= 33'(mulq(szsy_reg, cx_reg)) - 33'(czsx_reg);
            m_reg[2][0] <= 33'(nsy_reg);
            m_reg[2][1] <= 33'(cysx_reg);
            m_reg[2][2] <= 33'(cycx_reg);
        end
    end

    function automatic logic [CW-1:0] rot_out(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [33:0] q;
        t = 34'(v);
        if (WorkFrac - FB > 0)
            t = t + (34'sd1 <<< (WorkFrac - FB - 1));
        q = t >>> (WorkFrac - FB);
        if (q > (34'sd1 <<< FB))
            q = 34'sd1 <<< FB;
        if (q < -(34'sd1 <<< FB))
            q = -(34'sd1 <<< FB);
        return q[CW-1:0];
    endfunction

    // stage c: round into the row buffer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    out_col_reg[r][c] <= rot_out(m_reg[r][c]);
                out_off_reg[r] <= tr_pipe_reg[LAT-1][r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_full_reg <= 1'b0;
            row_reg      <= 2'd0;
        end
        else if (load)
        begin
            buf_full_reg <= 1'b1;
            row_reg      <= 2'd0;
        end
        else if (buf_full_reg && m_axis_tready)
        begin
            if (row_reg == 2'd2)
                buf_full_reg <= 1'b0;
            else
                row_reg <= row_reg + 2'd1;
        end
    end

    assign m_axis_tvalid = buf_full_reg;
    assign m_axis_tuser  = row_reg;
    assign m_axis_tlast  = (row_reg == 2'd2);
    always_comb
    begin
        m_axis_tdata = '0;
        unique case (row_reg)
            2'd0:    m_axis_tdata[DW-1:0] = {out_off_reg[0], out_col_reg[0][2],
                                             out_col_reg[0][1], out_col_reg[0][0]};
            2'd1:    m_axis_tdata[DW-1:0] = {out_off_reg[1], out_col_reg[1][2],
                                             out_col_reg[1][1], out_col_reg[1][0]};
            default: m_axis_tdata[DW-1:0] = {out_off_reg[2], out_col_reg[2][2],
                                             out_col_reg[2][1], out_col_reg[2][0]};
        endcase
    end

    `ASSERT_NEVER(a_row_range, clk, rst_n, row_reg == 2'd3, "row index out of range")
    `ASSERT_CLK(a_load_free, clk, rst_n,
        load |-> (!buf_full_reg || (m_axis_tready && row_reg == 2'd2)), "row buffer overwritten")
    `ASSERT_CLK(a_hold, clk, rst_n,
        (buf_full_reg && !m_axis_tready) |=> (buf_full_reg && $stable(row_reg)), "row lost on stall")
    `ASSERT_CLK(a_row_step, clk, rst_n,
        (buf_full_reg && m_axis_tready && row_reg != 2'd2) |=> (row_reg == $past(row_reg) + 2'd1),
        "row skipped")
endmodule
